// ===== src/sexpr_char_tokenizer_core_defines.svh =====
// assertion macros for the s-expression tokenizer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SEXPR_CHAR_TOKENIZER_CORE_DEFINES_SVH
`define SEXPR_CHAR_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication, idle during reset
`define SCT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sct_pkg.sv =====
// shared types and codes for the s-expression tokenizer
// no dependencies
package sct_pkg;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_CLOSE  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_ACCEPT = 2'd3;

    localparam logic [2:0] TT_OPEN  = 3'd0;
    localparam logic [2:0] TT_CLOSE = 3'd1;
    localparam logic [2:0] TT_TICK  = 3'd2;
    localparam logic [2:0] TT_SYMB  = 3'd3;
    localparam logic [2:0] TT_ATOM  = 3'd4;
    localparam logic [2:0] TT_PUNC  = 3'd5;
    localparam logic [2:0] TT_EOF   = 3'd6;

    localparam logic [1:0] ERR_UNEXPECTED   = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG     = 2'd1;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] ttype;
        logic [7:0] ch;
        logic [1:0] err;
    } result_t;

    // all results caused by one source byte
    typedef struct packed {
        logic [1:0]        count;
        logic [15:0]       line;
        result_t [2:0]     slot;
    } bundle_t;

endpackage

// ===== src/sct_if.sv =====
// valid/ready channel interfaces for the tokenizer input and result streams
// no dependencies
interface sct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

interface sct_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [2:0]  token_type;
    logic [7:0]  out_char;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic        last_result;

    modport source (output valid, output out_kind, output token_type, output out_char,
                    output line_number, output error_code, output last_result,
                    input ready);
    modport sink (input valid, input out_kind, input token_type, input out_char,
                  input line_number, input error_code, input last_result,
                  output ready);
endinterface

// ===== src/sct_queue.sv =====
// small fifo of per-byte result bundles between front and back
// depends on sct_pkg
module sct_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sct_pkg::bundle_t push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output sct_pkg::bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sct_pkg::bundle_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign not_full  = (cnt_reg != CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== src/sct_front.sv =====
// front end: takes one source byte per beat, runs the lexer state machine and
// packs the results of that byte into a bundle; depends on sct_pkg, sct_if
module sct_front (
    input  logic             clk,
    input  logic             rst_n,
    sct_in_if.sink           tok_in,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    input  logic             q_ready,
    output logic             q_push,
    output sct_pkg::bundle_t q_data
);

    localparam logic [3:0] M_START   = 4'd0;
    localparam logic [3:0] M_LIST    = 4'd1;
    localparam logic [3:0] M_LOWER   = 4'd2;
    localparam logic [3:0] M_HYPHEN  = 4'd3;
    localparam logic [3:0] M_UPPER   = 4'd4;
    localparam logic [3:0] M_SPACE   = 4'd5;
    localparam logic [3:0] M_DOT     = 4'd6;
    localparam logic [3:0] M_INT     = 4'd7;
    localparam logic [3:0] M_MINUS   = 4'd8;
    localparam logic [3:0] M_FRAC0   = 4'd9;
    localparam logic [3:0] M_FRAC    = 4'd10;
    localparam logic [3:0] M_STR     = 4'd11;
    localparam logic [3:0] M_STR_END = 4'd12;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_TICK   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;

    localparam logic [7:0]  MAX_LEN_RESET = 8'd254;
    localparam logic [15:0] LINE_RESET    = 16'd1;

    logic [3:0]  mode_reg, mode_next;
    logic [15:0] line_reg, line_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  max_len_reg;

    logic [7:0]  c;
    logic        is_low, is_up, is_dig, is_blank;
    logic        pre, add, post, nl, bad, acc, try_start, try_end;
    logic [2:0]  pre_t, post_t, word_t;
    logic [1:0]  bad_code;
    logic [3:0]  nx;
    logic [7:0]  len0;
    logic        add_fail, fail;
    logic [1:0]  fail_code;
    logic [15:0] line_new;
    logic [1:0]  n;
    sct_pkg::result_t [2:0] res;
    logic        accept;

    assign c        = tok_in.in_char;
    assign is_low   = (c >= 8'h61) && (c <= 8'h7a);
    assign is_up    = (c >= 8'h41) && (c <= 8'h5a);
    assign is_dig   = (c >= 8'h30) && (c <= 8'h39);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB);

    assign tok_in.ready = q_ready;
    assign accept       = tok_in.valid && q_ready;

    // action plan for one byte: [close pre_t] [append c] [close post_t]
    always_comb
    begin
        pre       = 1'b0;
        add       = 1'b0;
        post      = 1'b0;
        nl        = 1'b0;
        bad       = 1'b0;
        acc       = 1'b0;
        try_start = 1'b0;
        try_end   = 1'b0;
        pre_t     = sct_pkg::TT_SYMB;
        post_t    = sct_pkg::TT_CLOSE;
        word_t    = sct_pkg::TT_SYMB;
        bad_code  = sct_pkg::ERR_UNEXPECTED;
        nx        = mode_reg;

        case (mode_reg)
            M_START:
            begin
                if (c == CH_LPAREN)
                begin
                    add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_OPEN; nx = M_LIST;
                end
                else if (c == CH_RPAREN)
                begin
                    add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_CLOSE; nx = M_START;
                end
                else if (c == CH_NL)
                begin
                    nl = 1'b1;
                end
                else if (c == CH_SPACE)
                begin
                    nx = M_START;
                end
                else if (c == CH_TICK)
                begin
                    add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_TICK; nx = M_START;
                end
                else if (c == CH_NUL)
                begin
                    acc = 1'b1;
                end
                else
                begin
                    try_start = 1'b1;
                end
            end
            M_LIST:
            begin
                if (c == CH_LPAREN)
                begin
                    add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_OPEN; nx = M_START;
                end
                else if (c == CH_TICK)
                begin
                    add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_TICK; nx = M_START;
                end
                else if (c == CH_RPAREN)
                begin
                    add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_CLOSE; nx = M_START;
                end
                else if (is_low)
                begin
                    add = 1'b1; nx = M_LOWER;
                end
                else if (is_up)
                begin
                    add = 1'b1; nx = M_UPPER;
                end
                else if (is_blank)
                begin
                    pre = 1'b1; pre_t = sct_pkg::TT_SYMB; nx = M_LIST;
                end
                else if (c == CH_NL)
                begin
                    nl = 1'b1; pre = 1'b1; pre_t = sct_pkg::TT_SYMB; nx = M_LIST;
                end
                else
                begin
                    try_start = 1'b1;
                end
            end
            M_LOWER:
            begin
                if (is_low)
                begin
                    add = 1'b1; nx = M_LOWER;
                end
                else if (c == CH_MINUS)
                begin
                    add = 1'b1; nx = M_HYPHEN;
                end
                else
                begin
                    try_end = 1'b1; word_t = sct_pkg::TT_SYMB;
                end
            end
            M_HYPHEN:
            begin
                if (is_low)
                begin
                    add = 1'b1; nx = M_LOWER;
                end
                else if (c == CH_MINUS)
                begin
                    add = 1'b1; nx = M_HYPHEN;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            M_UPPER:
            begin
                if (is_up)
                begin
                    add = 1'b1; nx = M_UPPER;
                end
                else
                begin
                    try_end = 1'b1; word_t = sct_pkg::TT_ATOM;
                end
            end
            M_SPACE:
            begin
                if (c == CH_LPAREN)
                begin
                    add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_OPEN; nx = M_LIST;
                end
                else if (c == CH_TICK)
                begin
                    add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_TICK; nx = M_LIST;
                end
                else if (c == CH_RPAREN)
                begin
                    add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_CLOSE; nx = M_LIST;
                end
                else if (c == CH_DOT)
                begin
                    add = 1'b1; nx = M_DOT;
                end
                else if (is_low)
                begin
                    add = 1'b1; nx = M_LOWER;
                end
                else if (is_up)
                begin
                    add = 1'b1; nx = M_UPPER;
                end
                else if (is_blank)
                begin
                    nx = M_SPACE;
                end
                else if (c == CH_NL)
                begin
                    nl = 1'b1; nx = M_SPACE;
                end
                else
                begin
                    try_start = 1'b1;
                end
            end
            M_DOT:
            begin
                if (is_blank)
                begin
                    pre = 1'b1; pre_t = sct_pkg::TT_PUNC; nx = M_LIST;
                end
                else if (c == CH_NL)
                begin
                    nl = 1'b1; pre = 1'b1; pre_t = sct_pkg::TT_PUNC; nx = M_LIST;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            M_INT:
            begin
                if (is_dig)
                begin
                    add = 1'b1; nx = M_INT;
                end
                else if (c == CH_DOT)
                begin
                    add = 1'b1; nx = M_FRAC0;
                end
                else
                begin
                    try_end = 1'b1; word_t = sct_pkg::TT_ATOM;
                end
            end
            M_MINUS:
            begin
                if (is_dig)
                begin
                    add = 1'b1; nx = M_INT;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            M_FRAC0:
            begin
                if (is_dig)
                begin
                    add = 1'b1; nx = M_FRAC;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            M_FRAC:
            begin
                if (is_dig)
                begin
                    add = 1'b1; nx = M_FRAC;
                end
                else
                begin
                    try_end = 1'b1; word_t = sct_pkg::TT_ATOM;
                end
            end
            M_STR:
            begin
                if (c == CH_NUL)
                begin
                    bad = 1'b1; bad_code = sct_pkg::ERR_UNTERMINATED;
                end
                else if (c == CH_QUOTE)
                begin
                    pre = 1'b1; pre_t = sct_pkg::TT_ATOM; nx = M_STR_END;
                end
                else
                begin
                    add = 1'b1; nx = M_STR;
                end
            end
            M_STR_END:
            begin
                if ((c == CH_NL) || is_blank)
                begin
                    nx = M_SPACE;
                end
                else if (c == CH_RPAREN)
                begin
                    add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_CLOSE; nx = M_START;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase

        // start of a number or a string
        if (try_start)
        begin
            if (is_dig)
            begin
                add = 1'b1; nx = M_INT;
            end
            else if (c == CH_MINUS)
            begin
                add = 1'b1; nx = M_MINUS;
            end
            else if (c == CH_QUOTE)
            begin
                nx = M_STR;
            end
            else
            begin
                bad = 1'b1;
            end
        end

        // end of a symbol or atom word
        if (try_end)
        begin
            if (c == CH_RPAREN)
            begin
                pre = 1'b1; pre_t = word_t;
                add = 1'b1; post = 1'b1; post_t = sct_pkg::TT_CLOSE; nx = M_START;
            end
            else if (is_blank)
            begin
                pre = 1'b1; pre_t = word_t; nx = M_SPACE;
            end
            else if (c == CH_NL)
            begin
                nl = 1'b1; pre = 1'b1; pre_t = word_t; nx = M_SPACE;
            end
            else
            begin
                bad = 1'b1;
            end
        end
    end

    // evaluate the plan and pack the results in order
    always_comb
    begin
        len0      = pre ? 8'd0 : len_reg;
        add_fail  = add && (len0 >= max_len_reg);
        fail      = add_fail || bad;
        fail_code = add_fail ? sct_pkg::ERR_TOO_LONG : bad_code;
        line_new  = line_reg + {15'd0, nl};

        res = '0;
        n   = 2'd0;
        if (pre)
        begin
            res[n] = '{kind: sct_pkg::KIND_CLOSE, ttype: pre_t, ch: 8'd0, err: 2'd0};
            n = n + 2'd1;
        end
        if (add && !add_fail)
        begin
            res[n] = '{kind: sct_pkg::KIND_CHAR, ttype: 3'd0, ch: c, err: 2'd0};
            n = n + 2'd1;
        end
        if (post && !add_fail)
        begin
            res[n] = '{kind: sct_pkg::KIND_CLOSE, ttype: post_t, ch: 8'd0, err: 2'd0};
            n = n + 2'd1;
        end
        if (fail)
        begin
            res[n] = '{kind: sct_pkg::KIND_ERROR, ttype: 3'd0, ch: c, err: fail_code};
            n = n + 2'd1;
        end
        else if (acc)
        begin
            res[n] = '{kind: sct_pkg::KIND_ACCEPT, ttype: sct_pkg::TT_EOF, ch: 8'd0,
                       err: 2'd0};
            n = n + 2'd1;
        end

        if (fail || acc)
        begin
            mode_next = M_START;
            line_next = LINE_RESET;
            len_next  = 8'd0;
        end
        else
        begin
            mode_next = nx;
            line_next = line_new;
            if (post)
            begin
                len_next = 8'd0;
            end
            else if (add)
            begin
                len_next = len0 + 8'd1;
            end
            else
            begin
                len_next = len0;
            end
        end
    end

    assign q_push       = accept && (n != 2'd0);
    assign q_data.count = n;
    assign q_data.line  = line_new;
    assign q_data.slot  = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_START;
            line_reg    <= LINE_RESET;
            len_reg     <= 8'd0;
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
                line_reg <= line_next;
                len_reg  <= len_next;
            end
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== src/sct_back.sv =====
// back end: walks the results of the head bundle and drives the result
// channel from an output register; depends on sct_pkg, sct_if
module sct_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  sct_pkg::bundle_t q_head,
    output logic             q_pop,
    sct_out_if.source        tok_out
);

    logic [1:0]  sub_reg, sub_next;
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [2:0]  ttype_reg;
    logic [7:0]  char_reg;
    logic [15:0] line_reg;
    logic [1:0]  err_reg;
    logic        last_reg;

    logic             load, take, last;
    sct_pkg::result_t sel;

    assign load  = !out_valid_reg || tok_out.ready;
    assign take  = load && q_valid;
    assign sel   = q_head.slot[sub_reg];
    assign last  = (sub_reg == (q_head.count - 2'd1));
    assign q_pop = take && last;

    always_comb
    begin
        sub_next = sub_reg;
        if (take)
        begin
            sub_next = last ? 2'd0 : sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
            if (load)
            begin
                out_valid_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= sel.kind;
            ttype_reg <= sel.ttype;
            char_reg  <= sel.ch;
            line_reg  <= q_head.line;
            err_reg   <= sel.err;
            last_reg  <= last;
        end
    end

    assign tok_out.valid       = out_valid_reg;
    assign tok_out.out_kind    = kind_reg;
    assign tok_out.token_type  = ttype_reg;
    assign tok_out.out_char    = char_reg;
    assign tok_out.line_number = line_reg;
    assign tok_out.error_code  = err_reg;
    assign tok_out.last_result = last_reg;

endmodule

// ===== src/sexpr_char_tokenizer_core.sv =====
// byte-serial s-expression tokenizer: input byte channel, result beat channel
//
// tok_in carries one source byte per beat; a zero byte ends the text.
// tok_out carries one result per beat: token character, token close, syntax
// error or accepted end, with the line number and a last_result flag on the
// final result of each byte. A byte gives zero to three results.
// cfg_we/cfg_wdata write the token length limit (254 after reset); write it
// only while the block is idle.
// Results pass through the queue and the output register. Throughput: one
// byte per cycle while bytes give at most one result and the receiver is
// ready; the output register moves one result per cycle while not stalled,
// so a byte with three results holds the result side longer. Up to QUEUE_DEPTH
// bundles of results wait between the lexer and the output, and tok_in.ready
// drops only when that queue is full, e.g. when the receiver stalls.
// Reset: line 1, start mode, empty queue, no result pending.
// After an accepted end or an error the lexer restarts at line 1.
module sexpr_char_tokenizer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    sct_in_if.sink     tok_in,
    sct_out_if.source  tok_out,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic             q_push, q_not_full, q_pop, q_not_empty;
    sct_pkg::bundle_t q_wdata, q_head;

    sct_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_in    (tok_in),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_ready   (q_not_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    sct_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .tok_out (tok_out)
    );

endmodule

// ===== src/sct_checker.sv =====
// port-level checks on the tokenizer result channel, bound to the top level
// depends on sct_pkg and sexpr_char_tokenizer_core_defines.svh
`include "sexpr_char_tokenizer_core_defines.svh"

module sct_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [2:0]  token_type,
    input logic [7:0]  out_char,
    input logic [15:0] line_number,
    input logic [1:0]  error_code,
    input logic        last_result
);

    // a stalled result beat holds its kind, character, line number and last flag
    `SCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_char) && $stable(line_number) && $stable(last_result), "result beat changed while stalled")

    // error and accepted end are always the final result of their byte
    `SCT_ASSERT_IMPL(a_end_is_last, out_valid && (out_kind == sct_pkg::KIND_ERROR || out_kind == sct_pkg::KIND_ACCEPT), last_result, "error or end not flagged last")

    // token characters carry no type and no error code
    `SCT_ASSERT_IMPL(a_char_clean, out_valid && out_kind == sct_pkg::KIND_CHAR, token_type == 3'd0 && error_code == 2'd0, "token character with stray fields")

    // accepted end reports eof with empty character
    `SCT_ASSERT_IMPL(a_accept_eof, out_valid && out_kind == sct_pkg::KIND_ACCEPT, token_type == sct_pkg::TT_EOF && out_char == 8'd0, "accepted end without eof")

endmodule

bind sexpr_char_tokenizer_core sct_port_checks u_sct_port_checks (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (tok_out.valid),
    .out_ready   (tok_out.ready),
    .out_kind    (tok_out.out_kind),
    .token_type  (tok_out.token_type),
    .out_char    (tok_out.out_char),
    .line_number (tok_out.line_number),
    .error_code  (tok_out.error_code),
    .last_result (tok_out.last_result)
);

// ===== tb/sct_checker.sv =====
// result checker for the s-expression tokenizer: predicts the beats of every
// accepted source byte and compares them in order with the result channel
// depends on sct_pkg and the channel interfaces of sct_if.sv
module sct_checker (
    input  logic       clk,
    input  logic       rst_n,
    sct_in_if          in_ch,
    sct_out_if         out_ch,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    output int         fail_count,
    output int         pending,
    output int         beats_checked,
    output int         errors_seen,
    output int         accepts_seen
);

    localparam logic [2:0] TT_NONE        = 3'd0;
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [7:0] LIMIT_AT_RESET = 8'd254;
    localparam int         MAX_BEATS      = 3;

    // lexer modes
    localparam logic [3:0] M_START  = 4'd0;
    localparam logic [3:0] M_LIST   = 4'd1;
    localparam logic [3:0] M_LOWER  = 4'd2;
    localparam logic [3:0] M_DASH   = 4'd3;
    localparam logic [3:0] M_UPPER  = 4'd4;
    localparam logic [3:0] M_SEP    = 4'd5;
    localparam logic [3:0] M_DOT    = 4'd6;
    localparam logic [3:0] M_INT    = 4'd7;
    localparam logic [3:0] M_MINUS  = 4'd8;
    localparam logic [3:0] M_POINT  = 4'd9;
    localparam logic [3:0] M_FRAC   = 4'd10;
    localparam logic [3:0] M_STR    = 4'd11;
    localparam logic [3:0] M_QUOTED = 4'd12;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  ttype;
        logic [7:0]  ch;
        logic [15:0] line;
        logic [1:0]  err;
        logic        last;
    } beat_t;

    beat_t       expected_beats[$];
    beat_t       byte_beats[$];
    beat_t       want;
    logic [3:0]  lex_mode;
    logic [15:0] line_cnt;
    logic [7:0]  tok_len;
    logic [7:0]  len_limit;
    bit          lex_failed;
    logic [1:0]  lex_fcode;
    int          n_fail   = 0;
    int          n_beats  = 0;
    int          n_errors = 0;
    int          n_accept = 0;

    function automatic bit is_lower(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic bit is_upper(logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || c == "\t";
    endfunction

    function automatic void restart_lexer();
        lex_mode = M_START;
        line_cnt = 16'd1;
        tok_len  = 8'd0;
    endfunction

    function automatic void emit(logic [1:0] kind, logic [2:0] ttype, logic [7:0] ch,
                                 logic [1:0] err);
        beat_t b;
        if (byte_beats.size() >= MAX_BEATS)
            return;
        b.kind  = kind;
        b.ttype = ttype;
        b.ch    = ch;
        b.line  = line_cnt;
        b.err   = err;
        b.last  = 1'b0;
        byte_beats.push_back(b);
    endfunction

    function automatic void flag_error(logic [1:0] code);
        if (!lex_failed)
        begin
            lex_failed = 1'b1;
            lex_fcode  = code;
        end
    endfunction

    function automatic void add_char(logic [7:0] c);
        if (lex_failed)
            return;
        if (tok_len >= len_limit)
        begin
            flag_error(sct_pkg::ERR_TOO_LONG);
            return;
        end
        emit(sct_pkg::KIND_CHAR, TT_NONE, c, ERR_NONE);
        tok_len++;
    endfunction

    function automatic void close_token(logic [2:0] t);
        if (lex_failed)
            return;
        emit(sct_pkg::KIND_CLOSE, t, 8'h00, ERR_NONE);
        tok_len = 8'd0;
    endfunction

    function automatic logic [3:0] push_char(logic [7:0] c, logic [3:0] next);
        add_char(c);
        return next;
    endfunction

    // single-character token: the char then its close
    function automatic logic [3:0] lone_token(logic [7:0] c, logic [2:0] t, logic [3:0] next);
        add_char(c);
        close_token(t);
        return next;
    endfunction

    // the line count moves before the close so the close carries the new line
    function automatic logic [3:0] finish_token(logic [2:0] t, logic [3:0] next, bit nl);
        if (nl)
            line_cnt++;
        close_token(t);
        return next;
    endfunction

    function automatic logic [3:0] skip_space(logic [7:0] c, logic [3:0] next);
        if (c == "\n")
            line_cnt++;
        return next;
    endfunction

    // ')' blank or newline ends a symbol or atom word
    function automatic bit end_word(logic [7:0] c, logic [2:0] t, inout logic [3:0] nx);
        if (c == ")")
        begin
            close_token(t);
            add_char(c);
            close_token(sct_pkg::TT_CLOSE);
            nx = M_START;
            return 1'b1;
        end
        if (is_blank(c) || c == "\n")
        begin
            nx = finish_token(t, M_SEP, c == "\n");
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit start_value(logic [7:0] c, inout logic [3:0] nx);
        if (is_digit(c))
        begin
            nx = push_char(c, M_INT);
            return 1'b1;
        end
        if (c == "-")
        begin
            nx = push_char(c, M_MINUS);
            return 1'b1;
        end
        if (c == "\"")
        begin
            nx = M_STR;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        logic [3:0] nx;
        bit         accept;
        nx         = lex_mode;
        accept     = 1'b0;
        lex_failed = 1'b0;
        lex_fcode  = ERR_NONE;
        byte_beats.delete();
        case (lex_mode)
            M_START:
            begin
                if (c == "(") nx = lone_token(c, sct_pkg::TT_OPEN, M_LIST);
                else if (c == ")") nx = lone_token(c, sct_pkg::TT_CLOSE, M_START);
                else if (c == "\n" || c == " ") nx = skip_space(c, M_START);
                else if (c == "'") nx = lone_token(c, sct_pkg::TT_TICK, M_START);
                else if (c == 8'h00) accept = 1'b1;
                else if (!start_value(c, nx)) flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_LIST:
            begin
                if (c == "(") nx = lone_token(c, sct_pkg::TT_OPEN, M_START);
                else if (c == "'") nx = lone_token(c, sct_pkg::TT_TICK, M_START);
                else if (c == ")") nx = lone_token(c, sct_pkg::TT_CLOSE, M_START);
                else if (is_lower(c)) nx = push_char(c, M_LOWER);
                else if (is_upper(c)) nx = push_char(c, M_UPPER);
                // an empty symbol still closes here
                else if (is_blank(c) || c == "\n")
                    nx = finish_token(sct_pkg::TT_SYMB, M_LIST, c == "\n");
                else if (!start_value(c, nx)) flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_LOWER:
            begin
                if (is_lower(c)) nx = push_char(c, M_LOWER);
                else if (c == "-") nx = push_char(c, M_DASH);
                else if (!end_word(c, sct_pkg::TT_SYMB, nx))
                    flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_DASH:
            begin
                if (is_lower(c)) nx = push_char(c, M_LOWER);
                else if (c == "-") nx = push_char(c, M_DASH);
                else flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_UPPER:
            begin
                if (is_upper(c)) nx = push_char(c, M_UPPER);
                else if (!end_word(c, sct_pkg::TT_ATOM, nx))
                    flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_SEP:
            begin
                if (c == "(") nx = lone_token(c, sct_pkg::TT_OPEN, M_LIST);
                else if (c == "'") nx = lone_token(c, sct_pkg::TT_TICK, M_LIST);
                else if (c == ")") nx = lone_token(c, sct_pkg::TT_CLOSE, M_LIST);
                else if (c == ".") nx = push_char(c, M_DOT);
                else if (is_lower(c)) nx = push_char(c, M_LOWER);
                else if (is_upper(c)) nx = push_char(c, M_UPPER);
                else if (is_blank(c) || c == "\n") nx = skip_space(c, M_SEP);
                else if (!start_value(c, nx)) flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_DOT:
            begin
                if (is_blank(c) || c == "\n")
                    nx = finish_token(sct_pkg::TT_PUNC, M_LIST, c == "\n");
                else flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_INT:
            begin
                if (is_digit(c)) nx = push_char(c, M_INT);
                else if (c == ".") nx = push_char(c, M_POINT);
                else if (!end_word(c, sct_pkg::TT_ATOM, nx))
                    flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_MINUS:
            begin
                if (is_digit(c)) nx = push_char(c, M_INT);
                else flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_POINT:
            begin
                if (is_digit(c)) nx = push_char(c, M_FRAC);
                else flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_FRAC:
            begin
                if (is_digit(c)) nx = push_char(c, M_FRAC);
                else if (!end_word(c, sct_pkg::TT_ATOM, nx))
                    flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            M_STR:
            begin
                // newlines inside a string do not count a line
                if (c == 8'h00) flag_error(sct_pkg::ERR_UNTERMINATED);
                else if (c == "\"") nx = finish_token(sct_pkg::TT_ATOM, M_QUOTED, 1'b0);
                else nx = push_char(c, M_STR);
            end
            M_QUOTED:
            begin
                if (c == "\n" || is_blank(c)) nx = M_SEP;
                else if (c == ")") nx = lone_token(c, sct_pkg::TT_CLOSE, M_START);
                else flag_error(sct_pkg::ERR_UNEXPECTED);
            end
            default:
                flag_error(sct_pkg::ERR_UNEXPECTED);
        endcase

        if (lex_failed)
        begin
            emit(sct_pkg::KIND_ERROR, TT_NONE, c, lex_fcode);
            restart_lexer();
        end
        else if (accept)
        begin
            emit(sct_pkg::KIND_ACCEPT, sct_pkg::TT_EOF, 8'h00, ERR_NONE);
            restart_lexer();
        end
        else
            lex_mode = nx;

        if (byte_beats.size() > 0)
            byte_beats[byte_beats.size() - 1].last = 1'b1;
        foreach (byte_beats[i])
            expected_beats.push_back(byte_beats[i]);
    endfunction

    task automatic report(string msg);
        n_fail++;
        if (n_fail <= 40)
            $display("checker: %0t %s", $time, msg);
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] exp_val);
        if (got !== exp_val)
            report($sformatf("%s is %0h, predicted %0h", name, got, exp_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_lexer();
            len_limit = LIMIT_AT_RESET;
            expected_beats.delete();
            fail_count    <= 0;
            pending       <= 0;
            beats_checked <= 0;
            errors_seen   <= 0;
            accepts_seen  <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                n_beats++;
                if (expected_beats.size() == 0)
                    report($sformatf("result beat with nothing predicted, kind %0d char %02h",
                                     out_ch.out_kind, out_ch.out_char));
                else
                begin
                    want = expected_beats.pop_front();
                    compare_field("out_kind", 16'(out_ch.out_kind), 16'(want.kind));
                    compare_field("token_type", 16'(out_ch.token_type), 16'(want.ttype));
                    compare_field("out_char", 16'(out_ch.out_char), 16'(want.ch));
                    compare_field("line_number", out_ch.line_number, want.line);
                    compare_field("error_code", 16'(out_ch.error_code), 16'(want.err));
                    compare_field("last_result", 16'(out_ch.last_result), 16'(want.last));
                    if (want.kind == sct_pkg::KIND_ERROR)
                        n_errors++;
                    if (want.kind == sct_pkg::KIND_ACCEPT)
                        n_accept++;
                end
            end
            if (in_ch.valid && in_ch.ready)
                lex_byte(in_ch.in_char);
            if (cfg_we)
                len_limit = cfg_wdata;
            fail_count    <= n_fail;
            pending       <= expected_beats.size();
            beats_checked <= n_beats;
            errors_seen   <= n_errors;
            accepts_seen  <= n_accept;
        end
    end

endmodule

// ===== tb/tb_sexpr_char_tokenizer_core.sv =====
// testbench top for sexpr_char_tokenizer_core: feeds source text in bursts, stalls the
// result side, changes the token length limit between phases and gives the verdict
// depends on sct_pkg, sct_if.sv, tb/sct_checker.sv and the block itself
module tb_sexpr_char_tokenizer_core;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    sct_in_if  tok_in();
    sct_out_if tok_out();

    int fail_count;
    int pending;
    int beats_checked;
    int errors_seen;
    int accepts_seen;
    int bytes_sent   = 0;
    int burst_left   = 0;
    int n_settings   = 0;
    int stall_mode;
    int stall_cnt;

    sexpr_char_tokenizer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_in    (tok_in),
        .tok_out   (tok_out),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sct_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (tok_in),
        .out_ch        (tok_out),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked),
        .errors_seen   (errors_seen),
        .accepts_seen  (accepts_seen)
    );

    always #5 clk = ~clk;

    // receiver stalls: always ready, coin flips, rare drops, or a fixed duty pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tok_out.ready <= 1'b0;
            stall_mode    <= 0;
            stall_cnt     <= 0;
        end
        else
        begin
            if (stall_cnt == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_cnt  <= $urandom_range(20, 90);
            end
            else
                stall_cnt <= stall_cnt - 1;
            case (stall_mode)
                0: tok_out.ready <= 1'b1;
                1: tok_out.ready <= 1'($urandom_range(0, 1));
                2: tok_out.ready <= ($urandom_range(0, 7) != 0);
                default: tok_out.ready <= ((stall_cnt % 16) >= 10);
            endcase
        end
    end

    task automatic send_byte(logic [7:0] c);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                tok_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        tok_in.valid   <= 1'b1;
        tok_in.in_char <= c;
        @(posedge clk);
        while (!tok_in.ready) @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // hold the sender until every predicted beat is out, then let the block settle
    task automatic drain();
        tok_in.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_limit(logic [7:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_separator();
        case ($urandom_range(0, 4))
            0: send_byte("\n");
            1: send_byte("\t");
            default: send_byte(" ");
        endcase
    endtask

    task automatic send_digits(int lo, int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) send_byte(8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic send_string(int len, bit closed);
        logic [7:0] c;
        send_byte("\"");
        repeat (len)
        begin
            c = 8'($urandom_range(1, 255));
            if (c == "\"")
                c = "q";
            send_byte(c);
        end
        if (closed)
            send_byte("\"");
    endtask

    task automatic send_token(int max_word);
        int n;
        case ($urandom_range(0, 19))
            0, 1, 2: send_byte("(");
            3, 4, 5: send_byte(")");
            6: send_byte("'");
            7, 8, 9:
            begin
                n = $urandom_range(1, max_word);
                send_byte(8'("a" + $urandom_range(0, 25)));
                for (int i = 1; i < n; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_byte("-");
                    else
                        send_byte(8'("a" + $urandom_range(0, 25)));
                end
            end
            10, 11:
            begin
                n = $urandom_range(1, max_word);
                repeat (n) send_byte(8'("A" + $urandom_range(0, 25)));
            end
            12, 13:
            begin
                if ($urandom_range(0, 2) == 0)
                    send_byte("-");
                send_digits(1, 3);
                if ($urandom_range(0, 1) == 0)
                begin
                    send_byte(".");
                    send_digits(0, 3);
                end
            end
            14: send_string($urandom_range(0, 8), $urandom_range(0, 9) != 0);
            15: send_byte(".");
            16:
            begin
                if ($urandom_range(0, 1) == 0)
                    send_byte(8'($urandom_range(0, 255)));
                else
                    send_byte(8'h00);
            end
            default: send_separator();
        endcase
    endtask

    // mostly well-formed tokens with separators, closed with a zero byte
    task automatic random_text(int n_bytes, int max_word);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            send_token(max_word);
            if ($urandom_range(0, 9) < 7)
                send_separator();
        end
        send_byte(8'h00);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 8'd0;
        tok_in.valid   = 1'b0;
        tok_in.in_char = 8'd0;
        tok_out.ready  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit: empty symbol, dashed symbol, dot, string with newline, decimal
        send_text("( ab-c\n.\n\"x\n\"\n-1.5)");
        send_byte(8'h00);
        // zero inside a string, then a tick and an all-ones byte
        send_text("(\"a");
        send_byte(8'h00);
        send_byte("'");
        send_byte(8'hff);

        // one-character tokens: zero in a word, then an overflow
        write_limit(8'd1);
        send_text("(a");
        send_byte(8'h00);
        send_text("(AB");
        random_text(44, 3);

        // short limit: a string one byte too long overflows on its last content byte
        write_limit(8'd5);
        send_string(6, 1'b1);
        send_byte(8'h00);
        random_text(44, 8);

        write_limit(8'($urandom_range(2, 12)));
        random_text(44, 14);

        write_limit(8'($urandom_range(3, 40)));
        random_text(44, 10);

        write_limit(8'd254);
        random_text(44, 12);

        drain();
        $display("summary: %0d source bytes over %0d limit settings, %0d result beats checked",
                 bytes_sent, n_settings + 1, beats_checked);
        $display("summary: %0d syntax errors and %0d accepted texts among the results",
                 errors_seen, accepts_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sct_pkg.sv
src/sct_if.sv
src/sct_queue.sv
src/sct_front.sv
src/sct_back.sv
src/sexpr_char_tokenizer_core.sv
src/sct_checker.sv
tb/sct_checker.sv
tb/tb_sexpr_char_tokenizer_core.sv
